// ===== design/clcd_pkg.sv =====
package clcd_pkg;

  // request codes
  localparam logic [2:0] CMD_TICK   = 3'd0;
  localparam logic [2:0] CMD_INIT   = 3'd1;
  localparam logic [2:0] CMD_CLEAR  = 3'd2;
  localparam logic [2:0] CMD_CURSOR = 3'd3;
  localparam logic [2:0] CMD_CHAR   = 3'd4;

  // result status codes
  localparam logic [1:0] ST_ACCEPT = 2'd0;
  localparam logic [1:0] ST_REJECT = 2'd1;
  localparam logic [1:0] ST_IDLE   = 2'd2;

  // pending actions
  localparam logic [1:0] ACT_NONE    = 2'd0;
  localparam logic [1:0] ACT_START   = 2'd1;
  localparam logic [1:0] ACT_RELEASE = 2'd2;

  // configuration register indexes
  localparam logic [1:0] REG_WAIT      = 2'd0;
  localparam logic [1:0] REG_INIT_WAIT = 2'd1;
  localparam logic [1:0] REG_LONG_WAIT = 2'd2;

  localparam logic [7:0] WAIT_RESET      = 8'd2;
  localparam logic [7:0] INIT_WAIT_RESET = 8'd5;
  localparam logic [7:0] LONG_WAIT_RESET = 8'd20;

  localparam logic [6:0] LINE1_BASE   = 7'h40;
  localparam logic [7:0] NEWLINE_CODE = 8'd10;
  localparam logic [7:0] LCD_CLEAR    = 8'h01;
  localparam logic [7:0] LCD_DDRAM    = 8'h80;
  localparam logic [1:0] START_LAST   = 2'd2;
  localparam logic [1:0] START_DONE   = 2'd3;

  typedef struct packed {
    logic [2:0] cmd;
    logic [6:0] col;
    logic       row;
    logic [7:0] char_code;
  } clcd_req_t;

  typedef struct packed {
    logic [1:0] status;
    logic       bus_write;
    logic       reg_select;
    logic [7:0] bus_byte;
    logic       busy_res;
  } clcd_res_t;

  // start-up command bytes: function set, display on, entry mode
  function automatic logic [7:0] start_cmd(input logic [1:0] step);
    logic [7:0] b;
    b = 8'h06;
    unique case (step)
      2'd0:    b = 8'h38;
      2'd1:    b = 8'h0C;
      default: b = 8'h06;
    endcase
    return b;
  endfunction

endpackage

// ===== design/char_lcd_command_sequencer.sv =====
// Channel  | valid     | flow control | payload
// ---------+-----------+--------------+------------------------------
// request  | in_valid  | in_stall     | in_data  (clcd_req_t)
// result   | out_valid | out_stall    | out_data (clcd_res_t)
// config   | cfg_valid | cfg_ready    | cfg_index, cfg_data
//
// One request per cycle unless the result side stalls; request register,
// then result register. The sequencer state updates in the step between them.
// Reset (rst, synchronous) leaves the display busy until an init completes,
// with the delay registers at 2, 5 and 20 ticks.
// A stalled result holds the result register; the request register still
// takes one more request, and in_stall rises only when both are full.
module char_lcd_command_sequencer
  import clcd_pkg::*;
(
  input  logic       clk,
  input  logic       rst,
  input  logic       in_valid,
  output logic       in_stall,
  input  clcd_req_t  in_data,
  output logic       out_valid,
  input  logic       out_stall,
  output clcd_res_t  out_data,
  input  logic       cfg_valid,
  output logic       cfg_ready,
  input  logic [1:0] cfg_index,
  input  logic [7:0] cfg_data
);

  // delay registers
  logic [7:0] wait_ticks;
  logic [7:0] init_wait_ticks;
  logic [7:0] long_wait_ticks;

  // sequencer state
  logic       busy_flag,      busy_flag_next;
  logic [6:0] cursor_addr,    cursor_addr_next;
  logic [7:0] wait_count,     wait_count_next;
  logic [1:0] init_step,      init_step_next;
  logic [1:0] pending_action, pending_action_next;

  // request register
  logic      req_valid;
  clcd_req_t req;

  clcd_res_t res_next;
  logic      advance;

  assign cfg_ready = 1'b1;

  // the result register frees up when it is empty or being taken
  assign advance  = req_valid && (!out_valid || !out_stall);
  assign in_stall = req_valid && !advance;

  always_ff @(posedge clk) begin
    if (rst) begin
      wait_ticks      <= WAIT_RESET;
      init_wait_ticks <= INIT_WAIT_RESET;
      long_wait_ticks <= LONG_WAIT_RESET;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        REG_WAIT:      wait_ticks      <= cfg_data;
        REG_INIT_WAIT: init_wait_ticks <= cfg_data;
        REG_LONG_WAIT: long_wait_ticks <= cfg_data;
        default:       ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      req_valid <= 1'b0;
    end else if (!in_stall) begin
      req_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (!in_stall && in_valid) begin
      req <= in_data;
    end
  end

  // one request's worth of sequencer logic
  always_comb begin
    logic [7:0] dec;
    logic [1:0] s;
    logic [1:0] s_next;
    busy_flag_next      = busy_flag;
    cursor_addr_next    = cursor_addr;
    wait_count_next     = wait_count;
    init_step_next      = init_step;
    pending_action_next = pending_action;
    res_next            = '0;
    res_next.status     = ST_IDLE;
    dec    = (wait_count != 8'd0) ? wait_count - 8'd1 : wait_count;
    s      = (init_step > START_LAST) ? START_LAST : init_step;
    s_next = s + 2'd1;

    priority if (req.cmd == CMD_TICK) begin
      wait_count_next = dec;
      if (dec == 8'd0 && pending_action == ACT_RELEASE) begin
        busy_flag_next      = 1'b0;
        pending_action_next = ACT_NONE;
      end else if (dec == 8'd0 && pending_action == ACT_START) begin
        // start-up command fires on the tick
        res_next.bus_write = 1'b1;
        res_next.bus_byte  = start_cmd(s);
        init_step_next     = s_next;
        if (s_next != START_DONE) begin
          wait_count_next = (s_next == 2'd1) ? init_wait_ticks : wait_ticks;
        end else begin
          wait_count_next     = wait_ticks;
          pending_action_next = ACT_RELEASE;
        end
      end
    end else if (req.cmd == CMD_INIT) begin
      // restarts start-up regardless of busy; cursor kept
      busy_flag_next      = 1'b1;
      init_step_next      = 2'd0;
      pending_action_next = ACT_START;
      wait_count_next     = long_wait_ticks;
      res_next.status     = ST_ACCEPT;
    end else if (req.cmd > CMD_CHAR) begin
      res_next.status = ST_IDLE;
    end else if (busy_flag) begin
      res_next.status = ST_REJECT;
    end else begin
      res_next.status     = ST_ACCEPT;
      res_next.bus_write  = 1'b1;
      wait_count_next     = wait_ticks;
      busy_flag_next      = 1'b1;
      pending_action_next = ACT_RELEASE;
      priority if (req.cmd == CMD_CLEAR) begin
        res_next.bus_byte = LCD_CLEAR;
        cursor_addr_next  = 7'd0;
        wait_count_next   = long_wait_ticks;
      end else if (req.cmd == CMD_CURSOR) begin
        // seven-bit add wraps as the display address does
        cursor_addr_next  = (req.row ? LINE1_BASE : 7'd0) + req.col;
        res_next.bus_byte = LCD_DDRAM | {1'b0, cursor_addr_next};
      end else if (req.char_code == NEWLINE_CODE) begin
        cursor_addr_next  = LINE1_BASE;
        res_next.bus_byte = LCD_DDRAM | {1'b0, LINE1_BASE};
      end else begin
        res_next.reg_select = 1'b1;
        res_next.bus_byte   = req.char_code;
        cursor_addr_next    = cursor_addr + 7'd1;
      end
    end
    res_next.busy_res = busy_flag_next;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy_flag      <= 1'b1;
      cursor_addr    <= 7'd0;
      wait_count     <= 8'd0;
      init_step      <= 2'd0;
      pending_action <= ACT_NONE;
    end else if (advance) begin
      busy_flag      <= busy_flag_next;
      cursor_addr    <= cursor_addr_next;
      wait_count     <= wait_count_next;
      init_step      <= init_step_next;
      pending_action <= pending_action_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (advance) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      out_data <= res_next;
    end
  end

  // any pending action implies the display is held busy
  a_pending_busy: assert property (@(posedge clk) disable iff (rst)
    pending_action != ACT_NONE |-> busy_flag)
    else $error("pending action while not busy");

  // request side stalls only when both registers are occupied
  a_stall_full: assert property (@(posedge clk) disable iff (rst)
    in_stall |-> (out_valid && out_stall && req_valid))
    else $error("request stalled with free room");

  // quiet bus when no write
  a_quiet_bus: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_data.bus_write |->
      (out_data.reg_select == 1'b0 && out_data.bus_byte == 8'd0))
    else $error("bus driven without a write");

  // rejected requests never reach the display
  a_reject_no_write: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_data.status == ST_REJECT |->
      (!out_data.bus_write && out_data.busy_res))
    else $error("rejected request wrote the bus");

endmodule

// ===== test/char_lcd_command_sequencer_test.sv =====
`timescale 1ns / 1ps
module char_lcd_command_sequencer_test;
  import clcd_pkg::*;

  // cmd codes the block leaves alone
  localparam logic [2:0] CMD_SPARE_LO = 3'd5;
  localparam logic [2:0] CMD_SPARE_HI = 3'd7;

  localparam int CYCLE_LIMIT  = 400000;
  localparam int HOLD_CYCLES  = 80;  // long receiver hold-off
  localparam int DRAIN_CYCLES = 8;   // spare cycles after the last result is back

  logic       clk = 1'b0;
  logic       rst = 1'b1;
  logic       in_valid = 1'b0;
  logic       in_stall;
  clcd_req_t  in_data = '0;
  logic       out_valid;
  logic       out_stall = 1'b0;
  clcd_res_t  out_data;
  logic       cfg_valid = 1'b0;
  logic       cfg_ready;
  logic [1:0] cfg_index = '0;
  logic [7:0] cfg_data = '0;

  char_lcd_command_sequencer DUT (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  // ---------------------------------------------------------------------
  // Sequencer shadow: delay registers and state, as the block holds them
  // ---------------------------------------------------------------------
  logic [7:0] lcd_wait      = WAIT_RESET;
  logic [7:0] lcd_init_wait = INIT_WAIT_RESET;
  logic [7:0] lcd_long_wait = LONG_WAIT_RESET;
  logic       lcd_busy      = 1'b1;  // busy from reset until start-up ends
  logic [6:0] lcd_cursor    = '0;
  logic [7:0] lcd_count     = '0;
  logic [1:0] lcd_step      = '0;
  logic [1:0] lcd_action    = ACT_NONE;

  // results still owed by the block, oldest first
  clcd_res_t lcd_due[$];

  int sent            = 0;  // requests accepted by the block
  int results_checked = 0;  // results taken from the block (NBA, read by the sender)
  int fails           = 0;
  int cycles          = 0;
  int n_accept        = 0;
  int n_reject        = 0;
  int n_writes        = 0;
  int n_settings      = 0;

  logic no_idle = 1'b0;  // both sides stop idling while set
  logic hold_go = 1'b0;  // one long receiver hold-off when raised

  // Works out what one request does to the display bus and to the shadow.
  task automatic lcd_respond(input clcd_req_t r, output clcd_res_t res);
    logic [1:0] s;
    res = '0;
    case (r.cmd)
      CMD_TICK: begin
        res.status = ST_IDLE;
        if (lcd_count != 8'd0) lcd_count = lcd_count - 8'd1;
        if (lcd_count == 8'd0 && lcd_action == ACT_RELEASE) begin
          lcd_busy   = 1'b0;
          lcd_action = ACT_NONE;
        end else if (lcd_count == 8'd0 && lcd_action == ACT_START) begin
          // next start-up command fires on this tick
          s = (lcd_step > START_LAST) ? START_LAST : lcd_step;
          res.bus_write = 1'b1;
          case (s)
            2'd0:    res.bus_byte = 8'h38;
            2'd1:    res.bus_byte = 8'h0C;
            default: res.bus_byte = 8'h06;
          endcase
          lcd_step = s + 2'd1;
          if (lcd_step != START_DONE) begin
            lcd_count = (lcd_step == 2'd1) ? lcd_init_wait : lcd_wait;
          end else begin
            lcd_count  = lcd_wait;
            lcd_action = ACT_RELEASE;
          end
        end
      end
      CMD_INIT: begin
        // restarts start-up whatever is going on; cursor untouched
        res.status = ST_ACCEPT;
        lcd_busy   = 1'b1;
        lcd_step   = 2'd0;
        lcd_action = ACT_START;
        lcd_count  = lcd_long_wait;
      end
      CMD_CLEAR, CMD_CURSOR, CMD_CHAR: begin
        if (lcd_busy) begin
          res.status = ST_REJECT;
        end else begin
          res.status    = ST_ACCEPT;
          res.bus_write = 1'b1;
          lcd_count     = lcd_wait;
          if (r.cmd == CMD_CLEAR) begin
            res.bus_byte = LCD_CLEAR;
            lcd_cursor   = '0;
            lcd_count    = lcd_long_wait;
          end else if (r.cmd == CMD_CURSOR) begin
            lcd_cursor   = (r.row ? LINE1_BASE : 7'd0) + r.col;
            res.bus_byte = LCD_DDRAM | {1'b0, lcd_cursor};
          end else if (r.char_code == NEWLINE_CODE) begin
            lcd_cursor   = LINE1_BASE;
            res.bus_byte = LCD_DDRAM | {1'b0, LINE1_BASE};
          end else begin
            res.reg_select = 1'b1;
            res.bus_byte   = r.char_code;
            lcd_cursor     = lcd_cursor + 7'd1;
          end
          lcd_busy   = 1'b1;
          lcd_action = ACT_RELEASE;
        end
      end
      default: res.status = ST_IDLE;
    endcase
    res.busy_res = lcd_busy;
  endtask

  // ---------------------------------------------------------------------
  // Directed plan: request rows (optionally repeated) and register writes
  // ---------------------------------------------------------------------
  typedef struct {
    bit         reg_write;
    logic [1:0] reg_idx;
    logic [7:0] reg_val;
    clcd_req_t  req;
    int         reps;
    bit         fixed;  // res below is the expected result, typed in
    clcd_res_t  res;
  } step_row_t;

  function automatic step_row_t req_row(logic [2:0] cmd, logic [6:0] col, logic row,
                                        logic [7:0] ch, int reps);
    step_row_t p;
    p = '{default: '0};
    p.req  = '{cmd: cmd, col: col, row: row, char_code: ch};
    p.reps = reps;
    return p;
  endfunction

  function automatic step_row_t fixed_row(logic [2:0] cmd, logic [6:0] col, logic row,
                                          logic [7:0] ch, logic [1:0] st, logic busy);
    step_row_t p;
    p = req_row(cmd, col, row, ch, 1);
    p.fixed = 1'b1;
    p.res.status   = st;
    p.res.busy_res = busy;
    return p;
  endfunction

  function automatic step_row_t reg_row(logic [1:0] idx, logic [7:0] val);
    step_row_t p;
    p = '{default: '0};
    p.reg_write = 1'b1;
    p.reg_idx   = idx;
    p.reg_val   = val;
    return p;
  endfunction

  // Offer one request and hold it until taken; the expectation is
  // worked out at the accepting edge, then maybe a short gap follows.
  task automatic offer(input clcd_req_t r, input bit fixed, input clcd_res_t fixed_res);
    clcd_res_t got;
    in_valid <= 1'b1;
    in_data  <= r;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    lcd_respond(r, got);
    lcd_due.push_back(fixed ? fixed_res : got);
    sent++;
    if (!no_idle && $urandom_range(0, 99) < 11) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
  endtask

  // Stop offering and wait until every owed result has come back.
  task automatic drain_results();
    in_valid <= 1'b0;
    do @(posedge clk); while (results_checked < sent);
  endtask

  task automatic write_reg(input logic [1:0] idx, input logic [7:0] val);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    cfg_valid <= 1'b0;
    case (idx)
      REG_WAIT:      lcd_wait      = val;
      REG_INIT_WAIT: lcd_init_wait = val;
      REG_LONG_WAIT: lcd_long_wait = val;
      default: ;
    endcase
    @(posedge clk);
  endtask

  // ---------------------------------------------------------------------
  // Result side: random stall, one long hold-off, and the field check
  // ---------------------------------------------------------------------
  int  hold_left  = 0;
  bit  hold_taken = 1'b0;

  always @(posedge clk) begin
    if (rst) begin
      out_stall <= 1'b0;
    end else if (hold_go && !hold_taken) begin
      hold_taken <= 1'b1;
      hold_left  <= HOLD_CYCLES;
      out_stall  <= 1'b1;
    end else if (hold_left != 0) begin
      hold_left <= hold_left - 1;
      out_stall <= 1'b1;
    end else if (no_idle) begin
      out_stall <= 1'b0;
    end else begin
      out_stall <= ($urandom_range(0, 99) < 11);
    end
  end

  always @(posedge clk) begin
    clcd_res_t want;
    if (!rst && out_valid && !out_stall) begin
      results_checked <= results_checked + 1;
      if (lcd_due.size() == 0) begin
        $error("result %h with no request outstanding", out_data);
        fails++;
      end else begin
        want = lcd_due.pop_front();
        if (out_data.status !== want.status) begin
          $error("status: expected %0d, actual %0d", want.status, out_data.status);
          fails++;
        end
        if (out_data.bus_write !== want.bus_write) begin
          $error("bus_write: expected %0d, actual %0d", want.bus_write, out_data.bus_write);
          fails++;
        end
        if (out_data.reg_select !== want.reg_select) begin
          $error("reg_select: expected %0d, actual %0d", want.reg_select,
                 out_data.reg_select);
          fails++;
        end
        if (out_data.bus_byte !== want.bus_byte) begin
          $error("bus_byte: expected %h, actual %h", want.bus_byte, out_data.bus_byte);
          fails++;
        end
        if (out_data.busy_res !== want.busy_res) begin
          $error("busy_res: expected %0d, actual %0d", want.busy_res, out_data.busy_res);
          fails++;
        end
      end
      if (out_data.status == ST_ACCEPT) n_accept++;
      if (out_data.status == ST_REJECT) n_reject++;
      if (out_data.bus_write) n_writes++;
    end
  end

  // watchdog
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles == CYCLE_LIMIT) begin
      $error("timed out after %0d cycles, %0d results still owed", cycles, lcd_due.size());
      $display("char_lcd_command_sequencer: mismatch");
      $finish;
    end
  end

  // ---------------------------------------------------------------------
  // Stimulus
  // ---------------------------------------------------------------------
  initial begin
    step_row_t  plan[$];
    clcd_req_t  r;
    clcd_res_t  nil;
    logic [7:0] w, iw, lw;
    int         n;
    int         pick;

    nil = '0;

    // Before init, clear, cursor and char are refused; tick and spare codes do nothing.
    plan.push_back(fixed_row(CMD_CHAR, 7'd0, 1'b0, 8'h41, ST_REJECT, 1'b1));
    plan.push_back(fixed_row(CMD_CLEAR, 7'd0, 1'b0, 8'h00, ST_REJECT, 1'b1));
    plan.push_back(fixed_row(CMD_CURSOR, 7'd127, 1'b1, 8'hFF, ST_REJECT, 1'b1));
    plan.push_back(fixed_row(CMD_TICK, 7'd0, 1'b0, 8'h00, ST_IDLE, 1'b1));
    plan.push_back(fixed_row(CMD_SPARE_LO, 7'd0, 1'b0, 8'h00, ST_IDLE, 1'b1));
    plan.push_back(fixed_row(CMD_SPARE_HI, 7'd127, 1'b1, 8'hFF, ST_IDLE, 1'b1));
    // short delays, zero power-on delay: start-up fires on the first tick
    plan.push_back(reg_row(REG_WAIT, 8'd1));
    plan.push_back(reg_row(REG_INIT_WAIT, 8'd1));
    plan.push_back(reg_row(REG_LONG_WAIT, 8'd0));
    plan.push_back(fixed_row(CMD_INIT, 7'd0, 1'b0, 8'h00, ST_ACCEPT, 1'b1));
    plan.push_back(req_row(CMD_TICK, 7'd0, 1'b0, 8'h00, 4));   // three commands, release
    plan.push_back(req_row(CMD_CHAR, 7'd0, 1'b0, 8'h00, 1));   // code 0 is plain data
    plan.push_back(fixed_row(CMD_CHAR, 7'd0, 1'b0, 8'h41, ST_REJECT, 1'b1));
    plan.push_back(req_row(CMD_TICK, 7'd0, 1'b0, 8'h00, 1));
    plan.push_back(req_row(CMD_CHAR, 7'd0, 1'b0, 8'hFF, 1));
    plan.push_back(req_row(CMD_TICK, 7'd0, 1'b0, 8'h00, 1));
    plan.push_back(req_row(CMD_CHAR, 7'd0, 1'b0, NEWLINE_CODE, 1));
    plan.push_back(req_row(CMD_TICK, 7'd0, 1'b0, 8'h00, 1));
    plan.push_back(req_row(CMD_CURSOR, 7'd127, 1'b1, 8'h00, 1));  // wraps to 0x3F
    plan.push_back(req_row(CMD_TICK, 7'd0, 1'b0, 8'h00, 1));
    plan.push_back(req_row(CMD_CLEAR, 7'd0, 1'b0, 8'h00, 1));
    plan.push_back(req_row(CMD_TICK, 7'd0, 1'b0, 8'h00, 1));
    // init again part-way through start-up: back to the first command
    plan.push_back(fixed_row(CMD_INIT, 7'd0, 1'b0, 8'h00, ST_ACCEPT, 1'b1));
    plan.push_back(req_row(CMD_TICK, 7'd0, 1'b0, 8'h00, 2));
    plan.push_back(fixed_row(CMD_INIT, 7'd0, 1'b0, 8'h00, ST_ACCEPT, 1'b1));
    plan.push_back(req_row(CMD_TICK, 7'd0, 1'b0, 8'h00, 4));
    plan.push_back(req_row(CMD_CHAR, 7'd0, 1'b0, 8'h7F, 1));

    repeat (11) @(posedge clk);
    rst <= 1'b0;

    foreach (plan[i]) begin
      if (plan[i].reg_write) begin
        drain_results();
        write_reg(plan[i].reg_idx, plan[i].reg_val);
      end else begin
        repeat (plan[i].reps) offer(plan[i].req, plan[i].fixed, plan[i].res);
      end
    end
    n_settings = 1;

    // Random phases, each under its own delay setting. Every phase starts
    // with init; while busy the stream is mostly ticks so start-up and the
    // command delays run through, otherwise mostly real commands.
    for (int p = 0; p < 7; p++) begin
      case (p)
        0: begin w = 8'd1;   iw = 8'd1;   lw = 8'd1;   n = 150; end
        1: begin w = 8'd0;   iw = 8'd0;   lw = 8'd0;   n = 100; end
        2: begin
          w  = 8'($urandom_range(1, 40));
          iw = 8'($urandom_range(1, 40));
          lw = 8'($urandom_range(1, 40));
          n  = 150;
        end
        3: begin w = 8'd1;   iw = 8'd1;   lw = 8'd255; n = 280; end
        4: begin w = 8'd1;   iw = 8'd255; lw = 8'd1;   n = 280; end
        5: begin w = 8'd255; iw = 8'd2;   lw = 8'd2;   n = 340; end
        default: begin w = WAIT_RESET; iw = INIT_WAIT_RESET; lw = LONG_WAIT_RESET; n = 100; end
      endcase

      drain_results();
      write_reg(REG_WAIT, w);
      write_reg(REG_INIT_WAIT, iw);
      write_reg(REG_LONG_WAIT, lw);
      n_settings++;

      no_idle <= (p == 0);      // first phase runs flat out on both sides
      if (p == 2) hold_go <= 1'b1;  // receiver backs off, input must stall

      r = '{cmd: CMD_INIT, col: 7'($urandom_range(0, 127)), row: 1'($urandom_range(0, 1)),
            char_code: 8'($urandom_range(0, 255))};
      offer(r, 1'b0, nil);

      for (int k = 1; k < n; k++) begin
        pick        = $urandom_range(0, 99);
        r.col       = 7'($urandom_range(0, 127));
        r.row       = 1'($urandom_range(0, 1));
        r.char_code = 8'($urandom_range(0, 255));
        if (lcd_busy) begin
          if (pick < 90)      r.cmd = CMD_TICK;
          else if (pick < 93) r.cmd = CMD_INIT;
          else if (pick < 98) r.cmd = 3'($urandom_range(CMD_CLEAR, CMD_CHAR));
          else                r.cmd = 3'($urandom_range(CMD_SPARE_LO, CMD_SPARE_HI));
        end else begin
          if (pick < 25)      r.cmd = CMD_TICK;
          else if (pick < 28) r.cmd = CMD_INIT;
          else if (pick < 36) r.cmd = CMD_CLEAR;
          else if (pick < 56) r.cmd = CMD_CURSOR;
          else if (pick < 98) r.cmd = CMD_CHAR;
          else                r.cmd = 3'($urandom_range(CMD_SPARE_LO, CMD_SPARE_HI));
        end
        if (r.cmd == CMD_CHAR && $urandom_range(0, 7) == 0) r.char_code = NEWLINE_CODE;
        offer(r, 1'b0, nil);
      end
    end

    drain_results();
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (lcd_due.size() != 0) begin
      $error("%0d results never arrived", lcd_due.size());
      fails++;
    end

    $display("Sent %0d requests under %0d delay settings (zero and full-scale included).",
             sent, n_settings);
    $display("Results: %0d accepted, %0d refused while busy, %0d bytes on the bus.",
             n_accept, n_reject, n_writes);
    if (fails == 0) begin
      $display("char_lcd_command_sequencer: match");
    end else begin
      $display("char_lcd_command_sequencer: mismatch");
    end
    $finish;
  end

endmodule

// ===== sim.f =====
design/clcd_pkg.sv
design/char_lcd_command_sequencer.sv
test/char_lcd_command_sequencer_test.sv
